// File: sv/base64_stream_codec_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Base64 stream codec
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_CORE_ASSERT_SVH
`define BASE64_STREAM_CODEC_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define B64SC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("b64sc assertion failed");

// Condition that must hold in the cycle after the trigger.
`define B64SC_ASSERT_NEXT(name, clk, rst_n, trig, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("b64sc assertion failed");

`else

`define B64SC_ASSERT(name, clk, rst_n, prop)
`define B64SC_ASSERT_NEXT(name, clk, rst_n, trig, cons)

`endif

`endif

// File: sv/b64sc_pkg.sv
// ----------------------------------------------------------------------------
// Base64 stream codec package
// Payload types, the group record and the alphabet translation functions.
// ----------------------------------------------------------------------------
package b64sc_pkg;

    localparam logic       MODE_ENCODE = 1'b0;
    localparam logic       MODE_DECODE = 1'b1;
    localparam logic [7:0] CHAR_PAD    = 8'h3D;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       bad_char;
    } out_t;

    // One completed group: up to four results, item 0 goes out first.
    typedef struct packed {
        logic [3:0][7:0] items;
        logic [1:0]      last_idx;
        logic            last;
        logic            err;
    } group_rec_t;

    // 6-bit value to alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] idx);
        logic [7:0] r;
        case (idx) inside
            [6'd0:6'd25]:  r = 8'h41 + {2'b00, idx};
            [6'd26:6'd51]: r = 8'h47 + {2'b00, idx};
            [6'd52:6'd61]: r = {2'b00, idx} - 8'h04;
            6'd62:         r = 8'h2B;
            default:       r = 8'h2F;
        endcase
        return r;
    endfunction

    // Character to {in alphabet, 6-bit value}.
    function automatic logic [6:0] dec_char(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'h00;
        case (c) inside
            [8'h41:8'h5A]: begin
                d = c - 8'h41;
                r = {1'b1, d[5:0]};
            end
            [8'h61:8'h7A]: begin
                d = c - 8'h47;
                r = {1'b1, d[5:0]};
            end
            [8'h30:8'h39]: begin
                d = c + 8'h04;
                r = {1'b1, d[5:0]};
            end
            8'h2B:   r = {1'b1, 6'd62};
            8'h2F:   r = {1'b1, 6'd63};
            default: r = {1'b0, 6'd0};
        endcase
        return r;
    endfunction

endpackage

// File: sv/b64sc_group.sv
// ----------------------------------------------------------------------------
// Base64 group assembler
// Holds the mode register and the partial group, and builds a group record
// when an input transaction completes a group.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_core_assert.svh"

module b64sc_group (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  b64sc_pkg::in_t        s_data,
    input  logic                  pend_full,
    output logic                  rec_valid,
    output b64sc_pkg::group_rec_t rec
);

    logic        mode_reg;
    logic [23:0] bits_reg,  bits_next;
    logic [1:0]  count_reg, count_next;
    logic [1:0]  pad_reg,   pad_next;
    logic        err_reg,   err_next;

    logic        completes;
    logic        accept;
    logic [1:0]  pos_e;
    logic [23:0] enc_bits;
    logic [6:0]  dec;
    logic        is_pad;
    logic [5:0]  v;
    logic [7:0]  c;

    always_comb begin
        c        = s_data.in_byte;
        pos_e    = (count_reg == 2'd3) ? 2'd2 : count_reg;
        dec      = b64sc_pkg::dec_char(c);
        is_pad   = (c == b64sc_pkg::CHAR_PAD) && (count_reg >= 2'd2);
        v        = (is_pad || !dec[6]) ? 6'd0 : dec[5:0];
        enc_bits = bits_reg;
        rec      = '0;
        pad_next = pad_reg;
        err_next = err_reg;

        case (pos_e)
            2'd0:    enc_bits = bits_reg | {c, 16'h0000};
            2'd1:    enc_bits = bits_reg | {8'h00, c, 8'h00};
            default: enc_bits = bits_reg | {16'h0000, c};
        endcase

        if (mode_reg == b64sc_pkg::MODE_ENCODE) begin
            completes  = (pos_e == 2'd2) || s_data.in_last;
            bits_next  = enc_bits;
            count_next = pos_e + 2'd1;
            rec.items[0] = b64sc_pkg::enc_char(enc_bits[23:18]);
            rec.items[1] = b64sc_pkg::enc_char(enc_bits[17:12]);
            rec.items[2] = (pos_e == 2'd0) ? b64sc_pkg::CHAR_PAD
                                           : b64sc_pkg::enc_char(enc_bits[11:6]);
            rec.items[3] = (pos_e != 2'd2) ? b64sc_pkg::CHAR_PAD
                                           : b64sc_pkg::enc_char(enc_bits[5:0]);
            rec.last_idx = 2'd3;
            rec.err      = 1'b0;
        end else begin
            completes  = (count_reg == 2'd3) || s_data.in_last;
            pad_next   = pad_reg + {1'b0, is_pad};
            err_next   = err_reg | (!is_pad && !dec[6]);
            count_next = count_reg + 2'd1;
            case (count_reg)
                2'd0:    bits_next = bits_reg | {v, 18'h0};
                2'd1:    bits_next = bits_reg | {6'h0, v, 12'h0};
                2'd2:    bits_next = bits_reg | {12'h0, v, 6'h0};
                default: bits_next = bits_reg | {18'h0, v};
            endcase
            rec.items[0] = bits_next[23:16];
            rec.items[1] = bits_next[15:8];
            rec.items[2] = bits_next[7:0];
            rec.items[3] = 8'h00;
            // A lone character still yields one byte, its 6-bit value over zero bits, flagged bad.
            rec.last_idx = (count_reg == 2'd0) ? 2'd0 : count_reg - pad_next - 2'd1;
            rec.err      = err_next | (count_reg == 2'd0);
        end
        rec.last = s_data.in_last;
    end

    assign s_ready   = !completes || !pend_full;
    assign accept    = s_valid && s_ready;
    assign rec_valid = accept && completes;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= b64sc_pkg::MODE_ENCODE;
            bits_reg  <= '0;
            count_reg <= '0;
            pad_reg   <= '0;
            err_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            mode_reg  <= cfg_wr_data;
            bits_reg  <= '0;
            count_reg <= '0;
            pad_reg   <= '0;
            err_reg   <= 1'b0;
        end else if (accept) begin
            if (completes) begin
                bits_reg  <= '0;
                count_reg <= '0;
                pad_reg   <= '0;
                err_reg   <= 1'b0;
            end else begin
                bits_reg  <= bits_next;
                count_reg <= count_next;
                pad_reg   <= pad_next;
                err_reg   <= err_next;
            end
        end
    end

    `B64SC_ASSERT(a_enc_no_pad, aclk, aresetn, mode_reg || (pad_reg == 2'd0 && !err_reg))
    `B64SC_ASSERT(a_enc_count, aclk, aresetn, mode_reg || count_reg != 2'd3)
    `B64SC_ASSERT(a_pad_bound, aclk, aresetn, pad_reg != 2'd3)

endmodule

// File: sv/b64sc_emit.sv
// ----------------------------------------------------------------------------
// Base64 result emitter
// Two-entry group buffer that serializes each group record onto the result
// channel, one transaction per cycle while m_ready is high.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_core_assert.svh"

module b64sc_emit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rec_valid,
    input  b64sc_pkg::group_rec_t rec,
    output logic                  pend_full,
    output logic                  m_valid,
    input  logic                  m_ready,
    output b64sc_pkg::out_t       m_data
);

    logic                  act_valid_reg;
    b64sc_pkg::group_rec_t act_reg;
    logic [1:0]            idx_reg;
    logic                  pend_valid_reg;
    b64sc_pkg::group_rec_t pend_reg;

    logic act_at_end;
    logic act_done;
    logic act_free;

    assign act_at_end = (idx_reg == act_reg.last_idx);
    assign act_done   = act_valid_reg && m_ready && act_at_end;
    assign act_free   = !act_valid_reg || act_done;
    assign pend_full  = pend_valid_reg;

    assign m_valid         = act_valid_reg;
    assign m_data.out_byte = act_reg.items[idx_reg];
    assign m_data.out_last = act_reg.last && act_at_end;
    assign m_data.bad_char = act_reg.err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end else begin
            if (act_free) begin
                idx_reg <= '0;
                if (pend_valid_reg) begin
                    act_reg        <= pend_reg;
                    act_valid_reg  <= 1'b1;
                    pend_valid_reg <= 1'b0;
                end else if (rec_valid) begin
                    act_reg       <= rec;
                    act_valid_reg <= 1'b1;
                end else begin
                    act_valid_reg <= 1'b0;
                end
            end else begin
                if (m_ready) begin
                    idx_reg <= idx_reg + 2'd1;
                end
                // The input side only completes a group while this slot is empty.
                if (rec_valid) begin
                    pend_reg       <= rec;
                    pend_valid_reg <= 1'b1;
                end
            end
        end
    end

    `B64SC_ASSERT(a_pend_needs_act, aclk, aresetn, !pend_valid_reg || act_valid_reg)
    `B64SC_ASSERT(a_no_overrun, aclk, aresetn, !(rec_valid && pend_valid_reg))
    `B64SC_ASSERT(a_idx_bound, aclk, aresetn, !act_valid_reg || idx_reg <= act_reg.last_idx)
    `B64SC_ASSERT_NEXT(a_pend_drains, aclk, aresetn, act_done && pend_valid_reg,
                       act_valid_reg && idx_reg == 2'd0)

endmodule

// File: sv/base64_stream_codec_core.sv
// ----------------------------------------------------------------------------
// Base64 stream codec core
// Streaming RFC 4648 Base64 encoder/decoder with a one-bit mode register.
// ----------------------------------------------------------------------------
// With cfg_wr_data low the block encodes bytes into characters, four per group
// of three bytes, padding a short final group with '='; with it high it
// decodes characters into bytes, three per group of four less one per pad,
// and raises bad_char on every byte of a group that held a character outside
// the alphabet. Writing the mode register drops any partial group, so write
// it only between messages. The input side takes one transaction per cycle
// except when one that completes a group meets a full buffer; the result
// side gives one transaction per cycle while m_ready is high, so the
// sustained rate is set by the result port: encoding gives four results per
// three input bytes, decoding fewer than one per character. A completed group
// goes into the emitter's active slot, or into its buffer while one drains.
module base64_stream_codec_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  b64sc_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output b64sc_pkg::out_t m_data
);

    logic                  rec_valid;
    logic                  pend_full;
    b64sc_pkg::group_rec_t rec;

    b64sc_group u_group (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .pend_full   (pend_full),
        .rec_valid   (rec_valid),
        .rec         (rec)
    );

    b64sc_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (rec_valid),
        .rec       (rec),
        .pend_full (pend_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
